// ----- rtl/psv_pkg.sv -----
// ----------------------------------------------------------------------------
// psv_pkg
// Shared types and fixed constants of the pipelined prime sieve.
// ----------------------------------------------------------------------------
package psv_pkg;

	// width of the candidate and value_out fields on the stream ports
	localparam int unsigned FIELD_W = 16;

	// controller phases
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIVIDE,
		ST_SWEEP,
		ST_DONE
	} state_t;

	// per-cycle commands broadcast to every filter cell
	typedef struct packed {
		logic clear;   // restart the remainder at zero
		logic step;    // take one dividend bit into the remainder
		logic bit_in;  // dividend bit, most significant first
	} cell_cmd_t;

endpackage

// ----- rtl/psv_cell.sv -----
// ----------------------------------------------------------------------------
// psv_cell
// One filter cell: holds one stored prime, forms candidate mod prime one bit
// per cycle and passes a registered divisibility flag to its neighbor.
// ----------------------------------------------------------------------------
module psv_cell #(
	parameter int unsigned VALUE_BITS = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  psv_pkg::cell_cmd_t      cmd,
	input  logic                    valid,
	input  logic                    wr_en,
	input  logic [VALUE_BITS-1:0]   wr_data,
	input  logic                    hit_in,
	output logic                    hit_out
);

	logic [VALUE_BITS-1:0] prime_q;
	logic [VALUE_BITS-1:0] rem_q;
	logic                  hit_q;
	logic [VALUE_BITS:0]   rem_shift;
	logic [VALUE_BITS:0]   rem_sub;
	logic [VALUE_BITS-1:0] rem_next;

	// restoring remainder step: shift in one bit, subtract the prime if it fits
	always_comb begin
		rem_shift = {rem_q, cmd.bit_in};
		rem_sub   = rem_shift - {1'b0, prime_q};
		if (rem_shift >= {1'b0, prime_q}) begin
			rem_next = rem_sub[VALUE_BITS-1:0];
		end else begin
			rem_next = rem_shift[VALUE_BITS-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			prime_q <= wr_data;
		end
		if (cmd.clear) begin
			rem_q <= '0;
		end else if (cmd.step) begin
			rem_q <= rem_next;
		end
	end

	// the flag only counts for a cell that holds a prime
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q <= 1'b0;
		end else begin
			hit_q <= hit_in | (valid & (rem_q == '0));
		end
	end

	assign hit_out = hit_q;

endmodule

// ----- rtl/pipelined_prime_sieve.sv -----
// ----------------------------------------------------------------------------
// pipelined_prime_sieve
// Prime sieve built as a row of filter cells, one per stored prime.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake         | payload, lowest bits first
//  --------+-----------+-------------------+-----------------------------------------
//  s_axis  | in        | s_tvalid/s_tready | s_tdata[15:0] candidate
//  m_axis  | out       | m_tvalid/m_tready | m_tdata[15:0] value_out; m_tuser new, ovf
//
//  One item runs through the phases in order: the bit-serial remainder in
//  every cell at once (DIVIDE), the divisibility flag rippling down the cell
//  row (SWEEP), the commit (DONE), and an idle state to take the next item.
//  Reset clears the prime count and the output valid; stored primes need no
//  clearing since only cells below the count take part.
//  A result not yet taken holds in the output register; the next item is
//  still accepted and runs, and only its commit waits for the output to free.
// ----------------------------------------------------------------------------
module pipelined_prime_sieve #(
	parameter int unsigned MAX_PRIMES = 16,
	parameter int unsigned VALUE_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [psv_pkg::FIELD_W-1:0]   s_tdata,   // [15:0] candidate
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [psv_pkg::FIELD_W-1:0]   m_tdata,   // [15:0] value_out
	output logic [1:0]                    m_tuser    // [0] new_prime, [1] store_overflow
);

	localparam int unsigned CNT_W = $clog2(MAX_PRIMES + 1);
	localparam int unsigned DIV_W = $clog2(VALUE_BITS + 1);

	psv_pkg::state_t state_q, state_next;

	logic [VALUE_BITS-1:0]     val_q;      // masked candidate under test
	logic [VALUE_BITS-1:0]     shift_q;    // dividend bits, MSB first
	logic [DIV_W-1:0]          div_cnt_q;
	logic [CNT_W-1:0]          sweep_cnt_q;
	logic [CNT_W-1:0]          count_q;    // number of stored primes

	logic                      s_fire;
	logic                      commit;
	logic                      survivor;
	logic                      store_full;
	psv_pkg::cell_cmd_t        cmd;

	logic [MAX_PRIMES:0]       hit_chain;
	logic [MAX_PRIMES-1:0]     cell_valid;
	logic [MAX_PRIMES-1:0]     cell_wr;

	logic [psv_pkg::FIELD_W-1:0] out_data_q;
	logic                        out_new_q;
	logic                        out_over_q;
	logic                        out_valid_q;

	assign s_tready = (state_q == psv_pkg::ST_IDLE);
	assign s_fire   = s_tvalid & s_tready;

	// a candidate below two is never a survivor, whatever the cells say
	assign survivor   = (val_q >= VALUE_BITS'(2)) & ~hit_chain[MAX_PRIMES];
	assign store_full = (count_q == CNT_W'(MAX_PRIMES));

	// ---- next state and cell commands
	always_comb begin
		state_next = state_q;
		commit     = 1'b0;
		cmd.clear  = s_fire;
		cmd.step   = 1'b0;
		cmd.bit_in = shift_q[VALUE_BITS-1];
		case (state_q)
			psv_pkg::ST_IDLE: begin
				if (s_fire) begin
					state_next = psv_pkg::ST_DIVIDE;
				end
			end
			psv_pkg::ST_DIVIDE: begin
				cmd.step = 1'b1;
				if (div_cnt_q == DIV_W'(VALUE_BITS - 1)) begin
					state_next = psv_pkg::ST_SWEEP;
				end
			end
			psv_pkg::ST_SWEEP: begin
				if (sweep_cnt_q == CNT_W'(MAX_PRIMES - 1)) begin
					state_next = psv_pkg::ST_DONE;
				end
			end
			psv_pkg::ST_DONE: begin
				// hold until the output register is free
				if (!out_valid_q || m_tready) begin
					commit     = 1'b1;
					state_next = psv_pkg::ST_IDLE;
				end
			end
			default: begin
				state_next = psv_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= psv_pkg::ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	// ---- candidate and phase counters
	always_ff @(posedge clk) begin
		if (s_fire) begin
			val_q   <= VALUE_BITS'(s_tdata);
			shift_q <= VALUE_BITS'(s_tdata);
		end else if (cmd.step) begin
			shift_q <= shift_q << 1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_cnt_q   <= '0;
			sweep_cnt_q <= '0;
		end else begin
			if (state_q == psv_pkg::ST_DIVIDE) begin
				div_cnt_q <= div_cnt_q + 1'b1;
			end else begin
				div_cnt_q <= '0;
			end
			if (state_q == psv_pkg::ST_SWEEP) begin
				sweep_cnt_q <= sweep_cnt_q + 1'b1;
			end else begin
				sweep_cnt_q <= '0;
			end
		end
	end

	// ---- prime count: advance when a survivor is appended
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (commit && survivor && !store_full) begin
			count_q <= count_q + 1'b1;
		end
	end

	// ---- cell row; the flag enters clear at the head and ripples one cell a cycle
	assign hit_chain[0] = 1'b0;

	for (genvar i = 0; i < MAX_PRIMES; i++) begin : g_cell
		assign cell_valid[i] = (count_q > CNT_W'(i));
		assign cell_wr[i]    = commit & survivor & (count_q == CNT_W'(i));

		psv_cell #(
			.VALUE_BITS (VALUE_BITS)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.cmd     (cmd),
			.valid   (cell_valid[i]),
			.wr_en   (cell_wr[i]),
			.wr_data (val_q),
			.hit_in  (hit_chain[i]),
			.hit_out (hit_chain[i+1])
		);
	end

	// ---- output register
	always_ff @(posedge clk) begin
		if (commit) begin
			out_data_q <= psv_pkg::FIELD_W'(val_q);
			out_new_q  <= survivor & ~store_full;
			out_over_q <= survivor & store_full;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (commit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = {out_over_q, out_new_q};

endmodule
